@@ hdl/binary_to_ascii_decimal_defines.svh @@
// Assertion macros shared by the checker of the decimal converter.
`ifndef BINARY_TO_ASCII_DECIMAL_DEFINES_SVH
`define BINARY_TO_ASCII_DECIMAL_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and silenced while rst_ni is low.
`define BTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and silenced while rst_ni is low.
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bta_pkg.sv @@
// Shared constants and helpers of the binary to ASCII decimal converter.
package bta_pkg;

  // Width of one BCD digit.
  localparam int unsigned DIGIT_W = 4;

  // Width of one output character.
  localparam int unsigned CHAR_W = 6;

  // Width and reset value of the digit count register.
  localparam int unsigned CFG_W = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

  // Smallest number of characters emitted per item.
  localparam int unsigned DIGIT_FLOOR = 2;

  // ASCII code of the character zero, truncated to the character width.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  // Reciprocal of ten scaled by two to the power RECIP_SHIFT; exact for 32-bit operands.
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // Maps one decimal digit to its character code.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] digit);
    return ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digit};
  endfunction

endpackage

@@ hdl/bta_cell.sv @@
// One divide-by-ten cell of the digit extraction chain.
module bta_cell #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 7,
  parameter int unsigned INDEX       = 0
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [VALUE_WIDTH-1:0]                     value_i,
  input  logic [MAX_DIGITS-1:0][bta_pkg::DIGIT_W-1:0] digits_i,
  output logic                                       valid_o,
  output logic [VALUE_WIDTH-1:0]                     value_o,
  output logic [MAX_DIGITS-1:0][bta_pkg::DIGIT_W-1:0] digits_o
);
  import bta_pkg::*;

  localparam int unsigned PROD_W = VALUE_WIDTH + 32;

  logic [PROD_W-1:0]                     product;
  logic [VALUE_WIDTH-1:0]                quotient;
  logic [VALUE_WIDTH-1:0]                times_ten;
  logic [VALUE_WIDTH-1:0]                remainder;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]    digits_d;
  logic                                  valid_q;
  logic [VALUE_WIDTH-1:0]                value_q;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]    digits_q;

  // Quotient by reciprocal multiplication, remainder by shift and subtract.
  always_comb begin
    product   = PROD_W'(value_i) * PROD_W'(RECIP_TEN);
    quotient  = VALUE_WIDTH'(product >> RECIP_SHIFT);
    times_ten = (quotient << 3) + (quotient << 1);
    remainder = value_i - times_ten;
    digits_d  = digits_i;
    digits_d[INDEX] = remainder[DIGIT_W-1:0];
  end

  // Valid flag of the item held in this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload moves on together with the whole chain.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q  <= quotient;
      digits_q <= digits_d;
    end
  end

  assign valid_o  = valid_q;
  assign value_o  = value_q;
  assign digits_o = digits_q;

endmodule

@@ hdl/bta_serialiser.sv @@
// Emits the collected digits of one item as characters, most significant first.
module bta_serialiser #(
  parameter int unsigned MAX_DIGITS = 7
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  logic [MAX_DIGITS-1:0][bta_pkg::DIGIT_W-1:0] digits_i,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]            count_i,
  output logic                                       take_o,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [bta_pkg::CHAR_W-1:0]                 ascii_char_o,
  output logic                                       last_char_o
);
  import bta_pkg::*;

  localparam int unsigned POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                               valid_q, valid_d;
  logic [POS_W-1:0]                   pos_q, pos_d;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_q;
  logic                               out_accept;
  logic                               at_last;

  assign out_accept = valid_q && !out_stall_i;
  assign at_last    = (pos_q == '0);

  // Room for a new item once the current run hands over its final character.
  assign take_o = !valid_q || (out_accept && at_last);

  // Position counter steps down from the top digit to the units digit.
  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    if (load_i) begin
      valid_d = 1'b1;
      pos_d   = POS_W'(count_i - 1'b1);
    end else if (out_accept) begin
      if (at_last) begin
        valid_d = 1'b0;
      end else begin
        pos_d = pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      digits_q <= digits_i;
    end
  end

  // Character output straight from the held digits.
  assign out_valid_o  = valid_q;
  assign ascii_char_o = digit_to_ascii(digits_q[pos_q]);
  assign last_char_o  = at_last;

endmodule

@@ hdl/binary_to_ascii_decimal.sv @@
// Each item is registered in every cell and then in the serialiser before its first character.
// One character per cycle when not stalled; clamped digit_count characters per item.
// The MAX_DIGITS divide-by-ten cells form a pipeline; the character serialiser sets the rate.
// Reset clears the cell and serialiser valid flags and sets digit_count to three.
// The block accepts items in the first cycle after reset is released.
module binary_to_ascii_decimal #(
  parameter int unsigned MAX_DIGITS  = 7,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         digit_count_we_i,
  input  logic [bta_pkg::CFG_W-1:0]    digit_count_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [VALUE_WIDTH-1:0]       value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bta_pkg::CHAR_W-1:0]   ascii_char_o,
  output logic                         last_char_o
);
  import bta_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  logic [CFG_W-1:0]                   digit_count_q;
  logic [CNT_W-1:0]                   eff_count;
  logic                               advance;
  logic                               ser_take;
  logic                               ser_load;

  logic [MAX_DIGITS:0]                           chain_valid;
  logic [MAX_DIGITS:0][VALUE_WIDTH-1:0]          chain_value;
  logic [MAX_DIGITS:0][MAX_DIGITS-1:0][DIGIT_W-1:0] chain_digits;

  // Digit count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q <= CFG_RESET;
    end else if (digit_count_we_i) begin
      digit_count_q <= digit_count_i;
    end
  end

  // Clamp the count into the range the chain supports.
  always_comb begin
    if (int'(digit_count_q) < DIGIT_FLOOR) begin
      eff_count = CNT_W'(DIGIT_FLOOR);
    end else if (int'(digit_count_q) > MAX_DIGITS) begin
      eff_count = CNT_W'(MAX_DIGITS);
    end else begin
      eff_count = CNT_W'(digit_count_q);
    end
  end

  // The chain moves as one when its tail is empty or handed to the serialiser.
  assign ser_load   = chain_valid[MAX_DIGITS] && ser_take;
  assign advance    = !chain_valid[MAX_DIGITS] || ser_take;
  assign in_stall_o = !advance;

  assign chain_valid[0]  = in_valid_i;
  assign chain_value[0]  = value_i;
  assign chain_digits[0] = '0;

  // Row of cells, each peeling off one decimal digit.
  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    bta_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS),
      .INDEX       (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (advance),
      .valid_i  (chain_valid[k]),
      .value_i  (chain_value[k]),
      .digits_i (chain_digits[k]),
      .valid_o  (chain_valid[k+1]),
      .value_o  (chain_value[k+1]),
      .digits_o (chain_digits[k+1])
    );
  end

  // Character output stage.
  bta_serialiser #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_serialiser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (ser_load),
    .digits_i     (chain_digits[MAX_DIGITS]),
    .count_i      (eff_count),
    .take_o       (ser_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

@@ hdl/bta_checker.sv @@
// Port-level checker of the decimal converter, bound to the top level.
`include "binary_to_ascii_decimal_defines.svh"

module bta_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] ascii_char_o,
  input logic       last_char_o
);

  // A stalled item stays offered.
  `BTA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output item dropped while stalled")

  // A stalled item keeps its payload.
  `BTA_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(ascii_char_o) && $stable(last_char_o), "output payload changed while stalled")

  // Every character is a decimal digit.
  `BTA_ASSERT_NOW(a_char_range, out_valid_o, (ascii_char_o >= 6'd48) && (ascii_char_o <= 6'd57), "character outside the digit range")

  // A run of characters carries on without a gap until its final character.
  `BTA_ASSERT_NEXT(a_run_unbroken, out_valid_o && !out_stall_i && !last_char_o, out_valid_o, "gap inside a run of characters")

endmodule

bind binary_to_ascii_decimal bta_checker u_bta_checker (.*);
